[design/assembler_line_tokenizer_core_defines.svh]
// Assertion macros used by the checker file.
`ifndef ASSEMBLER_LINE_TOKENIZER_CORE_DEFINES_SVH
`define ASSEMBLER_LINE_TOKENIZER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the checker clock and held off in reset.
`define ALT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tokenizer assertion failed");

// Next-cycle implication.
`define ALT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tokenizer assertion failed");

`endif

[design/alt_pkg.sv]
`default_nettype none
package alt_pkg;

    localparam logic [2:0] MODE_NORMAL  = 3'd0;
    localparam logic [2:0] MODE_STRING  = 3'd1;
    localparam logic [2:0] MODE_COMMENT = 3'd2;
    localparam logic [2:0] MODE_SLASH   = 3'd3;
    localparam logic [2:0] MODE_LINECMT = 3'd4;
    localparam logic [2:0] MODE_ESC     = 3'd5;
    localparam logic [2:0] MODE_DIGITS  = 3'd6;

    localparam logic [1:0] ESC_NONE = 2'd0;
    localparam logic [1:0] ESC_DEC  = 2'd1;
    localparam logic [1:0] ESC_HEX  = 2'd2;
    localparam logic [1:0] ESC_OCT  = 2'd3;

    localparam logic [1:0] KIND_INSTR = 2'd0;
    localparam logic [1:0] KIND_LABEL = 2'd1;
    localparam logic [1:0] KIND_CONST = 2'd2;

    localparam logic [1:0] OUT_CHAR = 2'd0;
    localparam logic [1:0] OUT_EOW  = 2'd1;
    localparam logic [1:0] OUT_EOL  = 2'd2;

    localparam logic [7:0] CH_NL     = 8'd10;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;

    localparam int MAX_RES = 6;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  ch;
        logic [1:0]  lkind;
        logic        first;
        logic [15:0] lnum;
    } t_res;

    typedef struct packed {
        logic [2:0]           n;
        t_res [MAX_RES-1:0]   res;
    } t_bundle;

    typedef struct packed {
        logic [2:0]       mode;
        logic [1:0]       esc;
        logic [2:0][7:0]  held;
        logic [1:0]       hcount;
        logic             wchars;
        logic             lwords;
        logic [1:0]       kind;
    } t_state;

endpackage
`default_nettype wire

[design/alt_front.sv]
`default_nettype none
module alt_front #(
    parameter int LINE_NUMBER_BITS = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire logic [7:0]      i_in_char,
    input  wire logic            i_end_of_text,
    input  wire logic            i_full,
    output alt_pkg::t_bundle     o_bundle,
    output logic                 o_bundle_push,
    output logic                 o_full
);

    localparam logic [LINE_NUMBER_BITS-1:0] LINE_MAX = '1;
    localparam logic [LINE_NUMBER_BITS-1:0] LINE_ONE = LINE_NUMBER_BITS'(1);

    alt_pkg::t_state               r_st, n_st;
    logic [LINE_NUMBER_BITS-1:0]   r_line, n_line;
    logic [15:0]                   w_lnum;
    alt_pkg::t_bundle              w_b;
    logic                          w_eol, w_had, w_acc;

    generate
        if (LINE_NUMBER_BITS >= 16) begin : g_wide
            assign w_lnum = r_line[15:0];
        end else begin : g_narrow
            assign w_lnum = {{(16-LINE_NUMBER_BITS){1'b0}}, r_line};
        end
    endgenerate

    function automatic void emit(inout alt_pkg::t_bundle b, input logic [1:0] k,
                                 input logic [7:0] c, input logic [1:0] lk,
                                 input logic fw, input logic [15:0] ln);
        if (b.n < 3'(alt_pkg::MAX_RES)) begin
            b.res[b.n].kind  = k;
            b.res[b.n].ch    = c;
            b.res[b.n].lkind = lk;
            b.res[b.n].first = fw;
            b.res[b.n].lnum  = ln;
            b.n = b.n + 3'd1;
        end
    endfunction

    function automatic void emit_char(inout alt_pkg::t_state s, inout alt_pkg::t_bundle b,
                                      input logic [7:0] c_in, input logic [15:0] ln);
        logic [7:0] c;
        c = c_in;
        if (!s.lwords) begin
            if (!s.wchars) begin
                if (c == alt_pkg::CH_COLON) s.kind = alt_pkg::KIND_LABEL;
                else if (c == alt_pkg::CH_DOLLAR) s.kind = alt_pkg::KIND_CONST;
                else s.kind = alt_pkg::KIND_INSTR;
            end
            if (s.kind != alt_pkg::KIND_LABEL && c >= "a" && c <= "z") c = c - 8'd32;
        end
        emit(b, alt_pkg::OUT_CHAR, c, s.kind, !s.lwords, ln);
        s.wchars = 1'b1;
    endfunction

    function automatic void end_word(inout alt_pkg::t_state s, inout alt_pkg::t_bundle b,
                                     input logic force_end, input logic [15:0] ln);
        if (s.wchars || force_end) begin
            emit(b, alt_pkg::OUT_EOW, 8'd0, s.kind, !s.lwords, ln);
            s.lwords = 1'b1;
            s.wchars = 1'b0;
        end
    endfunction

    function automatic logic [3:0] digit_val(input logic [7:0] c, input logic [4:0] base);
        logic [3:0] v;
        v = 4'd0;
        if (c >= "0" && c <= "9") begin
            if (5'(c - "0") < base) v = 4'(c - "0");
        end else if (base == 5'd16 && c >= "a" && c <= "f") begin
            v = 4'(c - "a" + 8'd10);
        end else if (base == 5'd16 && c >= "A" && c <= "F") begin
            v = 4'(c - "A" + 8'd10);
        end
        return v;
    endfunction

    function automatic void end_line(inout alt_pkg::t_state s, inout alt_pkg::t_bundle b,
                                     input logic [15:0] ln, inout logic el, inout logic had);
        if (s.mode == alt_pkg::MODE_SLASH) begin
            emit_char(s, b, "/", ln);
        end else if (s.mode == alt_pkg::MODE_ESC) begin
            emit_char(s, b, "\\", ln);
        end else if (s.mode == alt_pkg::MODE_DIGITS) begin
            emit_char(s, b, "\\", ln);
            if (s.esc == alt_pkg::ESC_DEC || s.esc == alt_pkg::ESC_HEX) begin
                if (s.hcount > 2'd0) emit_char(s, b, s.held[0], ln);
                if (s.hcount > 2'd1) emit_char(s, b, s.held[1], ln);
                if (s.hcount > 2'd2) emit_char(s, b, s.held[2], ln);
            end
        end
        end_word(s, b, 1'b0, ln);
        if (s.lwords) emit(b, alt_pkg::OUT_EOL, 8'd0, s.kind, 1'b0, ln);
        el  = 1'b1;
        had = s.lwords;
        s.mode   = alt_pkg::MODE_NORMAL;
        s.esc    = alt_pkg::ESC_NONE;
        s.hcount = 2'd0;
        s.wchars = 1'b0;
        s.lwords = 1'b0;
        s.kind   = alt_pkg::KIND_INSTR;
    endfunction

    function automatic void normal_byte(inout alt_pkg::t_state s, inout alt_pkg::t_bundle b,
                                        input logic [7:0] c, input logic [15:0] ln);
        if (c == " " || c == 8'd9) end_word(s, b, 1'b0, ln);
        else if (c == "\"") s.mode = alt_pkg::MODE_STRING;
        else if (c == alt_pkg::CH_LBRACK) s.mode = alt_pkg::MODE_COMMENT;
        else if (c == "/") s.mode = alt_pkg::MODE_SLASH;
        else emit_char(s, b, c, ln);
    endfunction

    function automatic void escape_byte(inout alt_pkg::t_state s, inout alt_pkg::t_bundle b,
                                        input logic [7:0] c, input logic [15:0] ln);
        s.mode = alt_pkg::MODE_STRING;
        case (c)
            "\\": emit_char(s, b, "\\", ln);
            "\"": emit_char(s, b, "\"", ln);
            "n": emit_char(s, b, 8'd10, ln);
            "t": emit_char(s, b, 8'd9, ln);
            "b": emit_char(s, b, 8'd8, ln);
            "r": emit_char(s, b, 8'd13, ln);
            "v": emit_char(s, b, 8'd11, ln);
            "d": begin
                s.mode = alt_pkg::MODE_DIGITS;
                s.esc = alt_pkg::ESC_DEC;
                s.hcount = 2'd0;
            end
            "x": begin
                s.mode = alt_pkg::MODE_DIGITS;
                s.esc = alt_pkg::ESC_HEX;
                s.hcount = 2'd0;
            end
            default: begin
                if (c >= "0" && c <= "9") begin
                    s.mode = alt_pkg::MODE_DIGITS;
                    s.esc = alt_pkg::ESC_OCT;
                    s.held[0] = c;
                    s.hcount = 2'd1;
                end else begin
                    emit_char(s, b, "\\", ln);
                    emit_char(s, b, c, ln);
                end
            end
        endcase
    endfunction

    function automatic void digit_byte(inout alt_pkg::t_state s, inout alt_pkg::t_bundle b,
                                       input logic [7:0] c, input logic [15:0] ln);
        logic [1:0] need;
        logic [9:0] v;
        need = (s.esc == alt_pkg::ESC_DEC) ? 2'd3 : 2'd2;
        v = 10'd0;
        s.held[s.hcount] = c;
        s.hcount = s.hcount + 2'd1;
        if (s.hcount >= need) begin
            if (s.esc == alt_pkg::ESC_DEC) begin
                v = 10'(digit_val(s.held[0], 5'd10)) * 10'd100
                  + 10'(digit_val(s.held[1], 5'd10)) * 10'd10
                  + 10'(digit_val(s.held[2], 5'd10));
            end else if (s.esc == alt_pkg::ESC_HEX) begin
                v = {2'b00, digit_val(s.held[0], 5'd16), digit_val(s.held[1], 5'd16)};
            end else begin
                v = 10'(digit_val(s.held[0], 5'd8)) * 10'd8
                  + 10'(digit_val(s.held[1], 5'd8));
            end
            s.hcount = 2'd0;
            s.esc = alt_pkg::ESC_NONE;
            s.mode = alt_pkg::MODE_STRING;
            emit_char(s, b, v[7:0], ln);
        end
    endfunction

    always_comb begin
        n_st  = r_st;
        w_b   = '0;
        w_eol = 1'b0;
        w_had = 1'b0;
        if (i_in_char == alt_pkg::CH_NL) begin
            end_line(n_st, w_b, w_lnum, w_eol, w_had);
        end else begin
            unique case (r_st.mode)
                alt_pkg::MODE_NORMAL: normal_byte(n_st, w_b, i_in_char, w_lnum);
                alt_pkg::MODE_SLASH: begin
                    if (i_in_char == "/") begin
                        n_st.mode = alt_pkg::MODE_LINECMT;
                    end else begin
                        n_st.mode = alt_pkg::MODE_NORMAL;
                        emit_char(n_st, w_b, "/", w_lnum);
                        normal_byte(n_st, w_b, i_in_char, w_lnum);
                    end
                end
                alt_pkg::MODE_COMMENT: begin
                    if (i_in_char == alt_pkg::CH_RBRACK) n_st.mode = alt_pkg::MODE_NORMAL;
                end
                alt_pkg::MODE_STRING: begin
                    if (i_in_char == "\\") begin
                        n_st.mode = alt_pkg::MODE_ESC;
                    end else if (i_in_char == "\"") begin
                        n_st.mode = alt_pkg::MODE_NORMAL;
                        if (!n_st.wchars) end_word(n_st, w_b, 1'b1, w_lnum);
                    end else begin
                        emit_char(n_st, w_b, i_in_char, w_lnum);
                    end
                end
                alt_pkg::MODE_ESC: escape_byte(n_st, w_b, i_in_char, w_lnum);
                alt_pkg::MODE_DIGITS: digit_byte(n_st, w_b, i_in_char, w_lnum);
                default: ;
            endcase
            if (i_end_of_text) end_line(n_st, w_b, w_lnum, w_eol, w_had);
        end
    end

    always_comb begin
        n_line = r_line;
        if (w_eol && w_had && r_line != LINE_MAX) n_line = r_line + LINE_ONE;
        if (i_end_of_text) n_line = LINE_ONE;
    end

    assign w_acc         = i_push && !i_full;
    assign o_full        = i_full;
    assign o_bundle      = w_b;
    assign o_bundle_push = w_acc && (w_b.n != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.mode   <= alt_pkg::MODE_NORMAL;
            r_st.esc    <= alt_pkg::ESC_NONE;
            r_st.hcount <= 2'd0;
            r_st.wchars <= 1'b0;
            r_st.lwords <= 1'b0;
            r_st.kind   <= alt_pkg::KIND_INSTR;
            r_line      <= LINE_ONE;
        end else if (w_acc) begin
            r_st.mode   <= n_st.mode;
            r_st.esc    <= n_st.esc;
            r_st.held   <= n_st.held;
            r_st.hcount <= n_st.hcount;
            r_st.wchars <= n_st.wchars;
            r_st.lwords <= n_st.lwords;
            r_st.kind   <= n_st.kind;
            r_line      <= n_line;
        end
    end

endmodule
`default_nettype wire

[design/alt_back.sv]
`default_nettype none
module alt_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire alt_pkg::t_bundle  i_bundle,
    input  wire logic              i_bundle_push,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic                   o_empty,
    output alt_pkg::t_res          o_res,
    output logic                   o_last
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    alt_pkg::t_bundle  r_mem [DEPTH];
    logic [AW:0]       r_wptr, n_wptr;
    logic [AW:0]       r_rptr, n_rptr;
    logic [2:0]        r_idx, n_idx;
    alt_pkg::t_bundle  w_head;
    logic              w_done;

    assign o_empty = (r_wptr == r_rptr);
    assign o_full  = (r_wptr[AW] != r_rptr[AW]) && (r_wptr[AW-1:0] == r_rptr[AW-1:0]);
    assign w_head  = r_mem[r_rptr[AW-1:0]];
    assign o_res   = w_head.res[r_idx];
    assign o_last  = (r_idx == w_head.n - 3'd1);
    assign w_done  = i_pop && !o_empty && o_last;

    always_comb begin
        n_wptr = r_wptr + {{AW{1'b0}}, i_bundle_push};
        n_rptr = r_rptr + {{AW{1'b0}}, w_done};
        n_idx  = r_idx;
        if (i_pop && !o_empty) n_idx = o_last ? 3'd0 : r_idx + 3'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_idx  <= 3'd0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_bundle_push) r_mem[r_wptr[AW-1:0]] <= i_bundle;
    end

endmodule
`default_nettype wire

[design/assembler_line_tokenizer_core.sv]
// Assembler line tokenizer: takes one source byte per cycle and returns the word characters,
// end-of-word and end-of-line marks of each line, tagged with the line kind, the first-word
// flag and the line number. Each accepted byte yields zero to six result words, which are
// written as one group into a queue of four groups; a byte with no result takes no entry.
// A byte is taken every cycle while the queue has a free group. Result words are registered
// in the queue, reach the output once earlier groups have drained, and drain one per cycle
// while pop is held, so the sustained rate is one byte per cycle for bytes with at most one
// result and otherwise set by the count of results each byte produces.
`default_nettype none
module assembler_line_tokenizer_core #(
    parameter int LINE_NUMBER_BITS = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         push,
    output logic              full,
    input  wire logic [7:0]   i_in_char,
    input  wire logic         i_end_of_text,
    output logic              empty,
    input  wire logic         pop,
    output logic [1:0]        o_out_kind,
    output logic [7:0]        o_out_char,
    output logic [1:0]        o_line_kind,
    output logic              o_first_word,
    output logic [15:0]       o_line_number,
    output logic              o_last_of_run
);

    alt_pkg::t_bundle  w_bundle;
    logic              w_push, w_qfull;
    alt_pkg::t_res     w_res;

    alt_front #(.LINE_NUMBER_BITS(LINE_NUMBER_BITS)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_in_char     (i_in_char),
        .i_end_of_text (i_end_of_text),
        .i_full        (w_qfull),
        .o_bundle      (w_bundle),
        .o_bundle_push (w_push),
        .o_full        (full)
    );

    alt_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_bundle      (w_bundle),
        .i_bundle_push (w_push),
        .o_full        (w_qfull),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_res         (w_res),
        .o_last        (o_last_of_run)
    );

    assign o_out_kind    = w_res.kind;
    assign o_out_char    = w_res.ch;
    assign o_line_kind   = w_res.lkind;
    assign o_first_word  = w_res.first;
    assign o_line_number = w_res.lnum;

endmodule
`default_nettype wire

[design/alt_checker.sv]
`default_nettype none
`include "assembler_line_tokenizer_core_defines.svh"
module alt_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [1:0]  o_out_kind,
    input wire logic [7:0]  o_out_char,
    input wire logic        o_first_word,
    input wire logic [15:0] o_line_number
);

    `ALT_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(o_out_kind) && $stable(o_out_char))
    `ALT_ASSERT_NOW(a_kind, !empty, o_out_kind != alt_pkg::OUT_CHAR + 2'd3)
    `ALT_ASSERT_NOW(a_mark_zero, !empty && o_out_kind != alt_pkg::OUT_CHAR, o_out_char == 8'd0)
    `ALT_ASSERT_NOW(a_eol_first, !empty && o_out_kind == alt_pkg::OUT_EOL, !o_first_word)
    `ALT_ASSERT_NOW(a_line_nz, !empty, o_line_number != 16'd0)

endmodule

bind assembler_line_tokenizer_core alt_checker u_alt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .empty         (empty),
    .pop           (pop),
    .o_out_kind    (o_out_kind),
    .o_out_char    (o_out_char),
    .o_first_word  (o_first_word),
    .o_line_number (o_line_number)
);
`default_nettype wire
